// ===== sv/lkx_pkg.sv =====
// ----------------------------------------------------------------------------
// lkx_pkg
// Shared constants and the character map of the LCG key XOR stream cipher.
// ----------------------------------------------------------------------------
package lkx_pkg;

  localparam int unsigned KeyLengthDefault = 32;

  localparam logic [31:0] LcgMul = 32'd214013;
  localparam logic [31:0] LcgAdd = 32'd2531011;

  localparam int unsigned CharsetSize = 61;

  // floor(r * RecipMul / 2^RecipShift) == floor(r / 61) for every 15-bit r
  localparam logic [15:0] RecipMul   = 16'd34380;
  localparam int unsigned RecipShift = 21;

  localparam logic [5:0] LowerBase = 6'd0;
  localparam logic [5:0] UpperBase = 6'd26;
  localparam logic [5:0] DigitBase = 6'd52;

  function automatic logic [6:0] charset_lookup(input logic [5:0] idx);
    logic [7:0] code;
    code = 8'h00;
    priority if (idx < UpperBase) begin
      code = 8'h61 + {2'b00, idx - LowerBase};
    end else if (idx < DigitBase) begin
      code = 8'h41 + {2'b00, idx - UpperBase};
    end else if (idx < 6'(CharsetSize)) begin
      code = 8'h31 + {2'b00, idx - DigitBase};
    end else begin
      code = 8'h00;
    end
    return code[6:0];
  endfunction

endpackage

// ===== sv/lcg_key_xor_stream_cipher.sv =====
// ----------------------------------------------------------------------------
// lcg_key_xor_stream_cipher
// Repeating-key XOR stream cipher; the key is drawn from a seeded LCG.
// ----------------------------------------------------------------------------
// One byte per cycle unless the output stalls; each byte passes registers s1,
// s2 and out_data_q. The LCG recurrence is registered at accept; the key
// character is formed in a two-stage modulo/charset pipe, or read from the key
// memory once the key is complete (one read and one write port, forwarding
// from in-flight writes). A stalled output holds the whole pipe. tuser marks
// the first byte of a message, which reloads the LCG from the seed register.
// ----------------------------------------------------------------------------
module lcg_key_xor_stream_cipher
  import lkx_pkg::*;
#(
  parameter int unsigned KEY_LENGTH = KeyLengthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,    // seed
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_in
  input  logic [0:0]  s_axis_tuser,   // [0] start_req
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [7:0] data_out, [14:8] key_char
);

  localparam int unsigned AW = (KEY_LENGTH > 1) ? $clog2(KEY_LENGTH) : 1;

  typedef struct packed {
    logic          valid;
    logic          gen;
    logic [AW-1:0] pos;
    logic [7:0]    data;
    logic          hit1;
    logic          hit2;
    logic [6:0]    fwd;
  } s1_t;

  typedef struct packed {
    logic          valid;
    logic          gen;
    logic [AW-1:0] pos;
    logic [7:0]    data;
    logic [6:0]    key;
  } s2_t;

  logic [31:0]   seed_q;
  logic [31:0]   lcg_q, lcg_d;
  logic [AW-1:0] pos_q, pos_d;
  logic          cpl_q, cpl_d;
  logic [31:0]   cur_state;
  logic [AW-1:0] cur_pos;
  logic          cur_cpl;
  logic [AW:0]   pos_inc;
  logic          adv, acc;
  s1_t           s1_q, s1_d;
  s2_t           s2_q, s2_d;
  logic [6:0]    gen_char;
  logic [6:0]    s2_char;
  logic [6:0]    s1_key;
  logic          out_valid_q;
  logic [15:0]   out_data_q;
  logic [31:0]   st_q;
  logic [6:0]    key_mem [KEY_LENGTH];
  logic [6:0]    rdata_q;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign acc           = adv && s_axis_tvalid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_we_i) begin
      seed_q <= cfg_wdata_i;
    end
  end

  // Restart on start_req, then advance or reuse.
  always_comb begin
    cur_state = s_axis_tuser[0] ? seed_q : lcg_q;
    cur_pos   = s_axis_tuser[0] ? '0 : pos_q;
    cur_cpl   = s_axis_tuser[0] ? 1'b0 : cpl_q;
    pos_inc   = {1'b0, cur_pos} + (AW+1)'(1);
    lcg_d     = cur_cpl ? cur_state : cur_state * LcgMul + LcgAdd;
    if (pos_inc >= (AW+1)'(KEY_LENGTH)) begin
      pos_d = '0;
      cpl_d = 1'b1;
    end else begin
      pos_d = pos_inc[AW-1:0];
      cpl_d = cur_cpl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcg_q <= '0;
      pos_q <= '0;
      cpl_q <= 1'b0;
    end else if (acc) begin
      lcg_q <= lcg_d;
      pos_q <= pos_d;
      cpl_q <= cpl_d;
    end
  end

  always_comb begin
    s1_d       = '0;
    s1_d.valid = acc;
    s1_d.gen   = !cur_cpl;
    s1_d.pos   = cur_pos;
    s1_d.data  = s_axis_tdata;
    s1_d.hit1  = s1_q.valid && s1_q.gen && (s1_q.pos == cur_pos);
    s1_d.hit2  = s2_q.valid && s2_q.gen && (s2_q.pos == cur_pos);
    s1_d.fwd   = s2_char;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q <= lcg_d;
    end
  end

  lkx_char_map u_char_map (
    .clk_i   (clk_i),
    .en_i    (adv),
    .state_i (st_q),
    .char_o  (gen_char)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rdata_q <= key_mem[cur_pos];
      if (s2_q.valid && s2_q.gen) begin
        key_mem[s2_q.pos] <= s2_char;
      end
    end
  end

  // Forward from younger writer first.
  always_comb begin
    priority if (s1_q.hit1) begin
      s1_key = s2_char;
    end else if (s1_q.hit2) begin
      s1_key = s1_q.fwd;
    end else begin
      s1_key = rdata_q;
    end
    s2_d       = '0;
    s2_d.valid = s1_q.valid;
    s2_d.gen   = s1_q.gen;
    s2_d.pos   = s1_q.pos;
    s2_d.data  = s1_q.data;
    s2_d.key   = s1_key;
  end

  assign s2_char = s2_q.gen ? gen_char : s2_q.key;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q        <= '0;
      s2_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_q        <= s1_d;
      s2_q        <= s2_d;
      out_valid_q <= s2_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= {1'b0, s2_char, s2_q.data ^ {1'b0, s2_char}};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== sv/lkx_char_map.sv =====
// ----------------------------------------------------------------------------
// lkx_char_map
// Two-stage map from a generator state to a key character: bits 30..16 are
// reduced modulo 61 by a reciprocal multiply, then looked up in the charset.
// ----------------------------------------------------------------------------
module lkx_char_map
  import lkx_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] state_i,
  output logic [6:0]  char_o
);

  logic [14:0] rnd;
  logic [30:0] prod;
  logic [14:0] rnd_q;
  logic [9:0]  quot_q;
  logic [15:0] quot_x61;
  logic [14:0] rem;

  assign rnd  = state_i[30:16];
  assign prod = 31'({16'd0, rnd} * {15'd0, RecipMul});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rnd_q  <= rnd;
      quot_q <= prod[RecipShift +: 10];
    end
  end

  assign quot_x61 = 16'({6'd0, quot_q} * 16'(CharsetSize));
  assign rem      = rnd_q - quot_x61[14:0];
  assign char_o   = charset_lookup(rem[5:0]);

endmodule

// ===== tb/lcg_key_xor_stream_cipher_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcg_key_xor_stream_cipher_tb
// Streams byte messages through the cipher and checks every output beat
// against a cycle-free predictor of the LCG key generator and key memory.
// Seeds are changed only while the pipe is empty; both stream sides idle at
// random, one phase runs without idling and one holds the output off long
// enough to back the input up.
// ----------------------------------------------------------------------------
module lcg_key_xor_stream_cipher_tb;
  import lkx_pkg::*;

  localparam int unsigned KeyLen         = KeyLengthDefault;
  localparam int unsigned WatchdogLimit  = 2000;
  localparam int unsigned HoldOffCycles  = 300;
  localparam int unsigned IdlePercent    = 36;
  localparam int unsigned PhaseItems     = 270;
  localparam int unsigned RandomPhases   = 6;
  localparam int unsigned PressurePhase  = 2;
  localparam int unsigned NoIdlePhase    = 4;
  localparam int unsigned MaxReports     = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } plain_byte_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic [6:0] key_char;
  } cipher_beat_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [31:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [7:0] data_in
  logic [0:0]  s_axis_tuser  = '0;   // [0] start_req
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [7:0] data_out, [14:8] key_char

  plain_byte_t  plain_q[$];
  cipher_beat_t cipher_q[$];

  // predictor state
  logic [31:0] seed_shadow = '0;
  logic [31:0] lcg_shadow  = '0;
  logic [6:0]  key_shadow[KeyLen];
  int unsigned key_idx     = 0;
  bit          key_full    = 1'b0;

  bit          idle_on     = 1'b1;
  bit          stall_mode  = 1'b0;
  bit          stall_done  = 1'b0;
  int unsigned hold_cnt    = 0;
  logic        in_taken    = 1'b0;

  int unsigned err_cnt     = 0;
  int unsigned bytes_in    = 0;
  int unsigned msg_cnt     = 0;
  int unsigned msg_len     = 0;
  int unsigned longest_msg = 0;
  int unsigned seed_cnt    = 0;

  lcg_key_xor_stream_cipher dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  function automatic cipher_beat_t encipher_byte(logic [7:0] din, logic start);
    logic [14:0]  rnd;
    logic [5:0]   sel;
    logic [6:0]   kc;
    cipher_beat_t res;
    if (start) begin
      lcg_shadow = seed_shadow;
      key_idx    = 0;
      key_full   = 1'b0;
    end
    if (key_full) begin
      kc = key_shadow[key_idx];
    end else begin
      lcg_shadow = lcg_shadow * LcgMul + LcgAdd;
      rnd = lcg_shadow[30:16];
      sel = 6'(rnd % CharsetSize);
      if (sel < 26) begin
        kc = 7'h61 + 7'(sel);
      end else if (sel < 52) begin
        kc = 7'h41 + 7'(sel - 26);
      end else begin
        kc = 7'h31 + 7'(sel - 52);
      end
      key_shadow[key_idx] = kc;
    end
    if (key_idx + 1 >= KeyLen) begin
      key_idx  = 0;
      key_full = 1'b1;
    end else begin
      key_idx++;
    end
    res.data_out = din ^ {1'b0, kc};
    res.key_char = kc;
    return res;
  endfunction

  task automatic write_seed(logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    seed_shadow = value;
    seed_cnt++;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic queue_byte(logic [7:0] data, logic start);
    plain_byte_t it;
    it.data  = data;
    it.start = start;
    plain_q.push_back(it);
  endtask

  task automatic queue_message(int unsigned len, bit with_start);
    for (int unsigned i = 0; i < len; i++) begin
      queue_byte(8'($urandom), (i == 0) && with_start);
    end
  endtask

  task automatic drain_pipe();
    while (plain_q.size() != 0 || s_axis_tvalid || cipher_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // input driver
  always @(negedge clk_i) begin : drive_input
    plain_byte_t nxt;
    if (!s_axis_tvalid || in_taken) begin
      if (plain_q.size() != 0 && !(idle_on && $urandom_range(99) < IdlePercent)) begin
        nxt = plain_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nxt.data;
        s_axis_tuser  <= nxt.start;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output backpressure
  always @(negedge clk_i) begin : drive_ready
    if (stall_mode && !stall_done) begin
      m_axis_tready <= 1'b0;
      hold_cnt++;
      if (hold_cnt >= HoldOffCycles) stall_done = 1'b1;
    end else begin
      m_axis_tready <= !(idle_on && $urandom_range(99) < IdlePercent);
    end
  end

  // monitor and scoreboard
  always @(posedge clk_i) begin : monitor
    cipher_beat_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (cipher_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MaxReports) begin
            $display("unexpected output transaction: data %02h key %02h",
                     m_axis_tdata[7:0], m_axis_tdata[14:8]);
          end
        end else begin
          want = cipher_q.pop_front();
          if (m_axis_tdata[7:0] !== want.data_out || m_axis_tdata[14:8] !== want.key_char ||
              m_axis_tdata[15] !== 1'b0) begin
            err_cnt++;
            if (err_cnt <= MaxReports) begin
              $display("mismatch: expected data %02h key %02h, got data %02h key %02h pad %b",
                       want.data_out, want.key_char, m_axis_tdata[7:0],
                       m_axis_tdata[14:8], m_axis_tdata[15]);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        cipher_q.push_back(encipher_byte(s_axis_tdata, s_axis_tuser[0]));
        bytes_in++;
        if (s_axis_tuser[0]) begin
          msg_cnt++;
          msg_len = 1;
        end else begin
          msg_len++;
        end
        if (msg_len > longest_msg) longest_msg = msg_len;
      end
      in_taken <= s_axis_tvalid && s_axis_tready;
    end else begin
      in_taken <= 1'b0;
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("timeout: no transaction for %0d cycles", WatchdogLimit);
    $display("lcg_key_xor_stream_cipher_tb: errors");
    $finish;
  end

  initial begin : stimulus
    logic [31:0]  seeds[RandomPhases];
    int unsigned  filled;
    int unsigned  len;
    int unsigned  pick;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // no start after reset: key runs from generator state zero
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hff, 1'b0);
    queue_byte(8'ha5, 1'b0);
    queue_byte(8'h5a, 1'b0);
    drain_pipe();

    // seed change inside a message waits for the next start
    write_seed(32'hffff_ffff);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h7f, 1'b0);
    queue_byte(8'hff, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h55, 1'b0);
    queue_byte(8'haa, 1'b0);
    queue_byte(8'h0f, 1'b0);
    queue_byte(8'hf0, 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hff, 1'b0);
    queue_byte(8'h3c, 1'b0);
    queue_byte(8'hc3, 1'b0);
    queue_byte(8'h81, 1'b0);
    drain_pipe();

    // explicit zero seed must match the reset key
    write_seed(32'h0000_0000);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hff, 1'b0);
    queue_byte(8'ha5, 1'b0);
    queue_byte(8'h5a, 1'b0);
    drain_pipe();

    seeds[0] = 32'h0000_0000;
    seeds[1] = 32'hffff_ffff;
    seeds[2] = 32'h8000_0001;
    seeds[3] = 32'h7fff_fffe;
    seeds[4] = $urandom;
    seeds[5] = $urandom;

    for (int unsigned ph = 0; ph < RandomPhases; ph++) begin
      write_seed(seeds[ph]);
      idle_on    = (ph != NoIdlePhase);
      stall_mode = (ph == PressurePhase);
      filled = 0;
      while (filled < PhaseItems) begin
        pick = $urandom_range(99);
        if (pick < 5) begin
          len = 1;
        end else if (pick < 70) begin
          len = $urandom_range(40, 1);
        end else begin
          len = $urandom_range(130, 41);
        end
        // a few runs continue the previous message without a start
        queue_message(len, $urandom_range(99) >= 10);
        filled += len;
      end
      drain_pipe();
      stall_mode = 1'b0;
    end

    idle_on = 1'b0;
    drain_pipe();
    repeat (8) @(negedge clk_i);

    $display("summary: %0d bytes in %0d messages under %0d seed writes, longest message %0d",
             bytes_in, msg_cnt, seed_cnt, longest_msg);
    $display("summary: key reuse past %0d bytes, one output hold-off of %0d cycles",
             KeyLen, HoldOffCycles);
    if (err_cnt == 0) begin
      $display("lcg_key_xor_stream_cipher_tb: clean");
    end else begin
      $display("%0d failing transactions", err_cnt);
      $display("lcg_key_xor_stream_cipher_tb: errors");
    end
    $finish;
  end

endmodule
